// ===== design/rbst_pkg.sv =====
// shared constants and types for the ray box slab test block
`default_nettype none

package rbst_pkg;

    localparam int FRAC_BITS_DEFAULT = 16;
    localparam int COORD_W           = 32;
    localparam int CFG_IDX_W         = 3;
    localparam int PIPE_DEPTH        = 5;

    localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_Z = 3'd5;

    typedef struct packed {
        logic signed [COORD_W-1:0] near_d;
        logic signed [COORD_W-1:0] far_d;
    } axis_dist_t;

endpackage

`default_nettype wire

// ===== design/rbst_axis.sv =====
// per-axis slab distances: difference, multiply, scale and saturate, near/far order
`default_nettype none

module rbst_axis #(
    parameter int FRAC_BITS = rbst_pkg::FRAC_BITS_DEFAULT
) (
    input  wire logic                               clk,
    input  wire logic signed [rbst_pkg::COORD_W-1:0] box_lo,
    input  wire logic signed [rbst_pkg::COORD_W-1:0] box_hi,
    input  wire logic signed [rbst_pkg::COORD_W-1:0] origin,
    input  wire logic signed [rbst_pkg::COORD_W-1:0] inv_dir,
    output rbst_pkg::axis_dist_t                     slab_dist
);
    import rbst_pkg::*;

    localparam int DIFF_W   = COORD_W + 1;
    localparam int PROD_W   = DIFF_W + COORD_W;
    localparam int SCALED_W = PROD_W - FRAC_BITS;

    function automatic logic signed [COORD_W-1:0] saturate(
        input logic [SCALED_W-1:0] mag,
        input logic                neg
    );
        logic signed [COORD_W-1:0] res;
        if (neg)
        begin
            if (mag > SCALED_W'(64'h0000_0000_8000_0000))
                res = {1'b1, {(COORD_W-1){1'b0}}};
            else
                res = -$signed(mag[COORD_W-1:0]);
        end
        else
        begin
            if (mag > SCALED_W'(64'h0000_0000_7FFF_FFFF))
                res = {1'b0, {(COORD_W-1){1'b1}}};
            else
                res = $signed(mag[COORD_W-1:0]);
        end
        return res;
    endfunction

    // stage 1: exact differences and magnitudes
    logic signed [DIFF_W-1:0]  diff_lo_next;
    logic signed [DIFF_W-1:0]  diff_hi_next;
    logic        [DIFF_W-1:0]  mag_lo_next;
    logic        [DIFF_W-1:0]  mag_hi_next;
    logic        [COORD_W-1:0] inv_mag_next;
    logic        [DIFF_W-1:0]  mag_lo_reg;
    logic        [DIFF_W-1:0]  mag_hi_reg;
    logic        [COORD_W-1:0] inv_mag_reg;
    logic                      neg_lo_reg;
    logic                      neg_hi_reg;

    always_comb
    begin
        diff_lo_next = {box_lo[COORD_W-1], box_lo} - {origin[COORD_W-1], origin};
        diff_hi_next = {box_hi[COORD_W-1], box_hi} - {origin[COORD_W-1], origin};
        mag_lo_next  = diff_lo_next[DIFF_W-1] ? DIFF_W'(-diff_lo_next) : DIFF_W'(diff_lo_next);
        mag_hi_next  = diff_hi_next[DIFF_W-1] ? DIFF_W'(-diff_hi_next) : DIFF_W'(diff_hi_next);
        inv_mag_next = inv_dir[COORD_W-1] ? COORD_W'(-inv_dir) : COORD_W'(inv_dir);
    end

    always_ff @(posedge clk)
    begin
        mag_lo_reg  <= mag_lo_next;
        mag_hi_reg  <= mag_hi_next;
        inv_mag_reg <= inv_mag_next;
        neg_lo_reg  <= diff_lo_next[DIFF_W-1] ^ inv_dir[COORD_W-1];
        neg_hi_reg  <= diff_hi_next[DIFF_W-1] ^ inv_dir[COORD_W-1];
    end

    // stage 2: unsigned products
    logic [PROD_W-1:0] prod_lo_reg;
    logic [PROD_W-1:0] prod_hi_reg;
    logic              neg_lo2_reg;
    logic              neg_hi2_reg;

    always_ff @(posedge clk)
    begin
        prod_lo_reg <= PROD_W'(mag_lo_reg) * PROD_W'(inv_mag_reg);
        prod_hi_reg <= PROD_W'(mag_hi_reg) * PROD_W'(inv_mag_reg);
        neg_lo2_reg <= neg_lo_reg;
        neg_hi2_reg <= neg_hi_reg;
    end

    // stage 3: truncate toward zero, restore sign, saturate
    logic signed [COORD_W-1:0] t_lo_reg;
    logic signed [COORD_W-1:0] t_hi_reg;

    always_ff @(posedge clk)
    begin
        t_lo_reg <= saturate(prod_lo_reg[PROD_W-1:FRAC_BITS], neg_lo2_reg);
        t_hi_reg <= saturate(prod_hi_reg[PROD_W-1:FRAC_BITS], neg_hi2_reg);
    end

    // stage 4: order into near and far
    axis_dist_t dist_reg;

    always_ff @(posedge clk)
    begin
        if (t_lo_reg < t_hi_reg)
        begin
            dist_reg.near_d <= t_lo_reg;
            dist_reg.far_d  <= t_hi_reg;
        end
        else
        begin
            dist_reg.near_d <= t_hi_reg;
            dist_reg.far_d  <= t_lo_reg;
        end
    end

    assign slab_dist = dist_reg;

endmodule

`default_nettype wire

// ===== design/ray_box_slab_test_core.sv =====
// top level of the ray against axis-aligned box slab test pipeline
//
// usage:
//   box corners are written over the cfg channel (cfg_valid/cfg_ready, cfg_index,
//   cfg_data); index 0..5 selects min x/y/z then max x/y/z, other indexes are
//   ignored. cfg_ready is always high. write the box only while no ray is in flight.
//   a ray word is taken at each clock edge with start high and busy low; busy
//   stays low, so one ray can enter every cycle.
//   the hit word appears on hit with done high for one cycle, after the ray
//   has passed the per-axis chain: difference, 33x32 multiply, scale/saturate,
//   near/far order, then the entry/exit reduction and the final compare.
//   throughput is one ray per cycle.
//   the receiver cannot stall; every result is presented exactly once.
//   reset clears the box registers to zero and empties the pipeline; no
//   clearing pass is needed.
//   fixed point: signed, FRAC_BITS fraction bits in 32-bit words.
`default_nettype none

module ray_box_slab_test_core #(
    parameter int FRAC_BITS = rbst_pkg::FRAC_BITS_DEFAULT
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic signed [rbst_pkg::COORD_W-1:0]  origin_x,
    input  wire logic signed [rbst_pkg::COORD_W-1:0]  origin_y,
    input  wire logic signed [rbst_pkg::COORD_W-1:0]  origin_z,
    input  wire logic signed [rbst_pkg::COORD_W-1:0]  inv_dir_x,
    input  wire logic signed [rbst_pkg::COORD_W-1:0]  inv_dir_y,
    input  wire logic signed [rbst_pkg::COORD_W-1:0]  inv_dir_z,
    input  wire logic signed [rbst_pkg::COORD_W-1:0]  distance_limit,
    input  wire logic                                 limit_enable,
    output logic                                      done,
    output logic                                      hit,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic        [rbst_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic        [rbst_pkg::COORD_W-1:0]  cfg_data
);
    import rbst_pkg::*;

    logic accept;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    // box registers
    logic signed [COORD_W-1:0] box_min_x_reg;
    logic signed [COORD_W-1:0] box_min_y_reg;
    logic signed [COORD_W-1:0] box_min_z_reg;
    logic signed [COORD_W-1:0] box_max_x_reg;
    logic signed [COORD_W-1:0] box_max_y_reg;
    logic signed [COORD_W-1:0] box_max_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_min_x_reg <= '0;
            box_min_y_reg <= '0;
            box_min_z_reg <= '0;
            box_max_x_reg <= '0;
            box_max_y_reg <= '0;
            box_max_z_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_BOX_MIN_X: box_min_x_reg <= $signed(cfg_data);
                REG_BOX_MIN_Y: box_min_y_reg <= $signed(cfg_data);
                REG_BOX_MIN_Z: box_min_z_reg <= $signed(cfg_data);
                REG_BOX_MAX_X: box_max_x_reg <= $signed(cfg_data);
                REG_BOX_MAX_Y: box_max_y_reg <= $signed(cfg_data);
                REG_BOX_MAX_Z: box_max_z_reg <= $signed(cfg_data);
                default:       ;
            endcase
        end
    end

    // per-axis slab units
    axis_dist_t dist_x;
    axis_dist_t dist_y;
    axis_dist_t dist_z;

    rbst_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_x (
        .clk       (clk),
        .box_lo    (box_min_x_reg),
        .box_hi    (box_max_x_reg),
        .origin    (origin_x),
        .inv_dir   (inv_dir_x),
        .slab_dist (dist_x)
    );

    rbst_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_y (
        .clk       (clk),
        .box_lo    (box_min_y_reg),
        .box_hi    (box_max_y_reg),
        .origin    (origin_y),
        .inv_dir   (inv_dir_y),
        .slab_dist (dist_y)
    );

    rbst_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_z (
        .clk       (clk),
        .box_lo    (box_min_z_reg),
        .box_hi    (box_max_z_reg),
        .origin    (origin_z),
        .inv_dir   (inv_dir_z),
        .slab_dist (dist_z)
    );

    // valid bits and limit words travel alongside the axis pipeline
    logic [PIPE_DEPTH-1:0]     valid_reg;
    logic signed [COORD_W-1:0] limit_reg [PIPE_DEPTH];
    logic [PIPE_DEPTH-1:0]     lim_en_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[PIPE_DEPTH-2:0], accept};
    end

    always_ff @(posedge clk)
    begin
        limit_reg[0] <= distance_limit;
        lim_en_reg   <= {lim_en_reg[PIPE_DEPTH-2:0], limit_enable};
        for (int i = 1; i < PIPE_DEPTH; i++)
        begin
            limit_reg[i] <= limit_reg[i-1];
        end
    end

    // stage 5: latest entry, earliest exit
    logic signed [COORD_W-1:0] entry_xy_next;
    logic signed [COORD_W-1:0] exit_xy_next;
    logic signed [COORD_W-1:0] entry_next;
    logic signed [COORD_W-1:0] exit_next;
    logic signed [COORD_W-1:0] entry_reg;
    logic signed [COORD_W-1:0] exit_reg;

    always_comb
    begin
        entry_xy_next = (dist_x.near_d > dist_y.near_d) ? dist_x.near_d : dist_y.near_d;
        entry_next    = (dist_z.near_d > entry_xy_next) ? dist_z.near_d : entry_xy_next;
        exit_xy_next  = (dist_x.far_d < dist_y.far_d) ? dist_x.far_d : dist_y.far_d;
        exit_next     = (dist_z.far_d < exit_xy_next) ? dist_z.far_d : exit_xy_next;
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        exit_reg  <= exit_next;
    end

    // stage 6: hit decision
    logic signed [COORD_W-1:0] lower_next;
    logic                      hit_next;
    logic                      done_reg;
    logic                      hit_reg;

    always_comb
    begin
        lower_next = (entry_reg > 0) ? entry_reg : '0;
        hit_next   = (exit_reg >= lower_next)
                     && !(lim_en_reg[PIPE_DEPTH-1] && (entry_reg > limit_reg[PIPE_DEPTH-1]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
            hit_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= valid_reg[PIPE_DEPTH-1];
            hit_reg  <= valid_reg[PIPE_DEPTH-1] && hit_next;
        end
    end

    assign done = done_reg;
    assign hit  = hit_reg;

    // checks
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##(PIPE_DEPTH + 1) done)
        else $error("accepted ray word produced no result after pipeline latency");

    a_hit_marked: assert property (@(posedge clk) disable iff (!rst_n)
        hit |-> done)
        else $error("hit raised without result strobe");

    a_limit_rejects: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[PIPE_DEPTH-1] && lim_en_reg[PIPE_DEPTH-1]
         && (entry_reg > limit_reg[PIPE_DEPTH-1])) |=> !hit)
        else $error("hit reported with entry beyond enabled distance limit");

endmodule

`default_nettype wire

// ===== tb/tb_ray_box_slab_test_core.sv =====
// testbench for the ray box slab test core: directed and random rays checked against a slab predictor
module tb_ray_box_slab_test_core;

    import rbst_pkg::*;

    localparam int FRAC_BITS   = FRAC_BITS_DEFAULT;
    localparam int CYCLE_LIMIT = 100000;
    localparam int PHASE_RAYS  = 240;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_B = 3'd7;

    localparam logic signed [COORD_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] SAT_MIN = 32'sh8000_0000;

    typedef logic [2:0][COORD_W-1:0] vec3_t;

    typedef struct packed {
        vec3_t                     org;
        vec3_t                     inv;
        logic signed [COORD_W-1:0] limit;
        logic                      limit_en;
    } ray_t;

    logic clk = 1'b0;
    logic rst_n;
    logic start;
    logic busy;
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [COORD_W-1:0] origin_z;
    logic signed [COORD_W-1:0] inv_dir_x;
    logic signed [COORD_W-1:0] inv_dir_y;
    logic signed [COORD_W-1:0] inv_dir_z;
    logic signed [COORD_W-1:0] distance_limit;
    logic limit_enable;
    logic done;
    logic hit;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [COORD_W-1:0] cfg_data;

    vec3_t lo_corner = '0;
    vec3_t hi_corner = '0;
    logic hits_due[$];
    int error_count = 0;
    int cycle_count = 0;

    ray_box_slab_test_core #(
        .FRAC_BITS(FRAC_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .origin_x(origin_x),
        .origin_y(origin_y),
        .origin_z(origin_z),
        .inv_dir_x(inv_dir_x),
        .inv_dir_y(inv_dir_y),
        .inv_dir_z(inv_dir_z),
        .distance_limit(distance_limit),
        .limit_enable(limit_enable),
        .done(done),
        .hit(hit),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic signed [COORD_W-1:0] fx(input int n);
        return 32'(n * 65536);
    endfunction

    function automatic logic signed [COORD_W-1:0] clamp_q(input longint v);
        if (v > 64'sd2147483647)
            return SAT_MAX;
        if (v < -64'sd2147483648)
            return SAT_MIN;
        return 32'(v);
    endfunction

    function automatic int rand_span(input int bits);
        return int'($urandom_range(2 << bits)) - (1 << bits);
    endfunction

    // (corner - origin) * scale, truncated toward zero, saturated
    function automatic logic signed [COORD_W-1:0] slab_time(
        input logic signed [COORD_W-1:0] corner,
        input logic signed [COORD_W-1:0] origin,
        input logic signed [COORD_W-1:0] scale
    );
        longint gap;
        logic [63:0] gap_mag;
        logic [63:0] scale_mag;
        logic [63:0] mag;
        logic flip;
        gap = longint'(corner) - longint'(origin);
        flip = (gap < 0) != (scale < 0);
        gap_mag = (gap < 0) ? 64'(-gap) : 64'(gap);
        scale_mag = (scale < 0) ? 64'(-longint'(scale)) : 64'(longint'(scale));
        mag = (gap_mag * scale_mag) >> FRAC_BITS;
        if (flip)
        begin
            if (mag > 64'h8000_0000)
                mag = 64'h8000_0000;
            return 32'(-longint'(mag));
        end
        if (mag > 64'h7FFF_FFFF)
            mag = 64'h7FFF_FFFF;
        return 32'(mag);
    endfunction

    function automatic logic predict_hit(input ray_t r);
        logic signed [COORD_W-1:0] t_a;
        logic signed [COORD_W-1:0] t_b;
        logic signed [COORD_W-1:0] near_t;
        logic signed [COORD_W-1:0] far_t;
        logic signed [COORD_W-1:0] entry;
        logic signed [COORD_W-1:0] leave;
        logic signed [COORD_W-1:0] floor_t;
        logic result;
        entry = '0;
        leave = '0;
        for (int a = 0; a < 3; a++)
        begin
            t_a = slab_time(lo_corner[a], r.org[a], r.inv[a]);
            t_b = slab_time(hi_corner[a], r.org[a], r.inv[a]);
            near_t = (t_a < t_b) ? t_a : t_b;
            far_t = (t_a < t_b) ? t_b : t_a;
            if (a == 0 || near_t > entry)
                entry = near_t;
            if (a == 0 || far_t < leave)
                leave = far_t;
        end
        floor_t = (entry > 32'sd0) ? entry : 32'sd0;
        result = (leave >= floor_t);
        if (r.limit_en && entry > $signed(r.limit))
            result = 1'b0;
        return result;
    endfunction

    function automatic ray_t mk_ray(
        input logic signed [COORD_W-1:0] ox, oy, oz,
        input logic signed [COORD_W-1:0] ix, iy, iz,
        input logic signed [COORD_W-1:0] lim,
        input logic en
    );
        ray_t r;
        r.org = {oz, oy, ox};
        r.inv = {iz, iy, ix};
        r.limit = lim;
        r.limit_en = en;
        return r;
    endfunction

    // ray from near the box toward a point inside it, reached at distance one
    function automatic ray_t aimed_ray();
        ray_t r;
        longint lo;
        longint hi;
        longint target;
        longint offs;
        longint dir;
        for (int a = 0; a < 3; a++)
        begin
            lo = longint'($signed(lo_corner[a]));
            hi = longint'($signed(hi_corner[a]));
            if (lo > hi)
            begin
                target = lo;
                lo = hi;
                hi = target;
            end
            target = lo + longint'({$urandom, $urandom} >> 1) % (hi - lo + 1);
            offs = longint'(rand_span(22));
            if ($urandom_range(3) == 0)
                offs = offs <<< 8;
            r.org[a] = clamp_q(target + offs);
            dir = target - longint'($signed(r.org[a]));
            r.inv[a] = (dir == 0) ? SAT_MAX : clamp_q((longint'(1) <<< 32) / dir);
        end
        return r;
    endfunction

    function automatic ray_t random_ray();
        ray_t r;
        int pick;
        longint center;
        pick = $urandom_range(99);
        if (pick < 45)
            r = aimed_ray();
        else if (pick < 80)
        begin
            for (int a = 0; a < 3; a++)
            begin
                center = (longint'($signed(lo_corner[a])) +
                          longint'($signed(hi_corner[a]))) / 2;
                r.org[a] = clamp_q(center + longint'(rand_span(22)));
                case ($urandom_range(19))
                    0, 1: r.inv[a] = '0;
                    2: r.inv[a] = SAT_MAX;
                    3: r.inv[a] = SAT_MIN;
                    default: r.inv[a] = rand_span(18);
                endcase
            end
        end
        else
        begin
            r.org = {$urandom, $urandom, $urandom};
            r.inv = {$urandom, $urandom, $urandom};
        end
        case ($urandom_range(3))
            0, 1: r.limit = rand_span(17);
            2: r.limit = rand_span(24);
            default: r.limit = $urandom;
        endcase
        r.limit_en = 1'($urandom_range(1));
        return r;
    endfunction

    // reference copy of the box and the expected hit words
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_BOX_MIN_X: lo_corner[0] = cfg_data;
                    REG_BOX_MIN_Y: lo_corner[1] = cfg_data;
                    REG_BOX_MIN_Z: lo_corner[2] = cfg_data;
                    REG_BOX_MAX_X: hi_corner[0] = cfg_data;
                    REG_BOX_MAX_Y: hi_corner[1] = cfg_data;
                    REG_BOX_MAX_Z: hi_corner[2] = cfg_data;
                    default: ;
                endcase
            end
            if (start && !busy)
                hits_due.push_back(predict_hit(mk_ray(origin_x, origin_y, origin_z,
                    inv_dir_x, inv_dir_y, inv_dir_z, distance_limit, limit_enable)));
            if (done)
            begin
                if (hits_due.size() == 0)
                begin
                    $display("%0t unexpected hit word: expected none actual %0b", $time, hit);
                    error_count++;
                end
                else if (hits_due[0] !== hit)
                begin
                    $display("%0t hit mismatch: expected %0b actual %0b",
                             $time, hits_due[0], hit);
                    error_count++;
                    void'(hits_due.pop_front());
                end
                else
                    void'(hits_due.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[ray_box_slab_test_core] ERROR");
            $finish;
        end
    end

    task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [COORD_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic load_box(input vec3_t lo, input vec3_t hi);
        reg_write(REG_BOX_MIN_X, lo[0]);
        reg_write(REG_BOX_MIN_Y, lo[1]);
        reg_write(REG_BOX_MIN_Z, lo[2]);
        reg_write(REG_BOX_MAX_X, hi[0]);
        reg_write(REG_BOX_MAX_Y, hi[1]);
        reg_write(REG_BOX_MAX_Z, hi[2]);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_ray(input ray_t r);
        start <= 1'b1;
        origin_x <= r.org[0];
        origin_y <= r.org[1];
        origin_z <= r.org[2];
        inv_dir_x <= r.inv[0];
        inv_dir_y <= r.inv[1];
        inv_dir_z <= r.inv[2];
        distance_limit <= r.limit;
        limit_enable <= r.limit_en;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (hits_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic load_unit_box();
        settle();
        load_box({fx(-1), fx(-1), fx(-1)}, {fx(1), fx(1), fx(1)});
    endtask

    task automatic test_axis_rays();
        load_unit_box();
        send_ray(mk_ray(fx(-5), 0, 0, fx(1), SAT_MAX, SAT_MAX, 0, 1'b0));
        send_ray(mk_ray(fx(-5), fx(2), 0, fx(1), SAT_MAX, SAT_MAX, 0, 1'b0));
        send_ray(mk_ray(fx(5), 0, 0, fx(1), SAT_MAX, SAT_MAX, 0, 1'b0));
        send_ray(mk_ray(fx(5), 0, 0, fx(-1), SAT_MAX, SAT_MAX, 0, 1'b0));
        send_ray(mk_ray(0, 0, 0, fx(1), fx(1), fx(1), 0, 1'b0));
        send_ray(mk_ray(fx(-3), fx(-3), fx(-3), fx(1), fx(1), fx(1), 0, 1'b0));
    endtask

    task automatic test_zero_inverse();
        load_unit_box();
        send_ray(mk_ray(fx(7), fx(7), fx(7), 0, 0, 0, 0, 1'b0));
        send_ray(mk_ray(fx(-5), 0, 0, fx(1), 0, 0, 0, 1'b0));
    endtask

    task automatic test_distance_limit();
        load_unit_box();
        send_ray(mk_ray(fx(-5), 0, 0, fx(1), SAT_MAX, SAT_MAX, fx(3), 1'b1));
        send_ray(mk_ray(fx(-5), 0, 0, fx(1), SAT_MAX, SAT_MAX, fx(4), 1'b1));
        send_ray(mk_ray(fx(-5), 0, 0, fx(1), SAT_MAX, SAT_MAX, fx(3), 1'b0));
        send_ray(mk_ray(0, 0, 0, fx(1), SAT_MAX, SAT_MAX, fx(-2), 1'b1));
        send_ray(mk_ray(0, 0, 0, fx(1), SAT_MAX, SAT_MAX, SAT_MIN, 1'b1));
        send_ray(mk_ray(fx(-5), 0, 0, fx(1), SAT_MAX, SAT_MAX, SAT_MAX, 1'b1));
    endtask

    task automatic test_field_extremes();
        settle();
        load_box({SAT_MIN, SAT_MIN, SAT_MIN}, {SAT_MAX, SAT_MAX, SAT_MAX});
        send_ray(mk_ray(SAT_MIN, SAT_MIN, SAT_MIN, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MIN, 1'b1));
        send_ray(mk_ray(SAT_MAX, SAT_MAX, SAT_MAX, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MAX, 1'b1));
        send_ray(mk_ray(SAT_MIN, SAT_MAX, SAT_MIN, SAT_MIN, SAT_MAX, SAT_MIN, SAT_MIN, 1'b0));
        send_ray(mk_ray(SAT_MAX, SAT_MIN, SAT_MAX, SAT_MAX, SAT_MIN, SAT_MAX, 0, 1'b1));
    endtask

    task automatic test_swapped_corners();
        settle();
        load_box({fx(1), fx(1), fx(1)}, {fx(-1), fx(-1), fx(-1)});
        send_ray(mk_ray(fx(-5), 0, 0, fx(1), SAT_MAX, SAT_MAX, 0, 1'b0));
        send_ray(mk_ray(fx(-5), fx(2), 0, fx(1), SAT_MAX, SAT_MAX, 0, 1'b0));
    endtask

    task automatic test_flat_box();
        settle();
        load_box({fx(-1), fx(-1), fx(2)}, {fx(1), fx(1), fx(2)});
        send_ray(mk_ray(0, 0, fx(-5), SAT_MAX, SAT_MAX, fx(1), 0, 1'b0));
        send_ray(mk_ray(fx(3), 0, fx(-5), SAT_MAX, SAT_MAX, fx(1), 0, 1'b0));
    endtask

    task automatic test_unused_index();
        load_unit_box();
        @(posedge clk);
        reg_write(REG_UNUSED_A, SAT_MIN);
        reg_write(REG_UNUSED_B, SAT_MAX);
        cfg_valid <= 1'b0;
        send_ray(mk_ray(fx(-5), 0, 0, fx(1), SAT_MAX, SAT_MAX, 0, 1'b0));
        send_ray(mk_ray(fx(-5), fx(2), 0, fx(1), SAT_MAX, SAT_MAX, 0, 1'b0));
    endtask

    // bursts of rays with random gaps between them
    task automatic send_stream(input int count);
        int burst_left;
        int gap;
        burst_left = 0;
        for (int n = 0; n < count; n++)
        begin
            if (burst_left == 0)
            begin
                gap = ($urandom_range(4) == 0) ? 0 : $urandom_range(6, 1);
                burst_left = ($urandom_range(7) == 0) ? $urandom_range(150, 60)
                                                      : $urandom_range(20, 1);
                if (gap != 0)
                begin
                    start <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            send_ray(random_ray());
            burst_left--;
        end
    endtask

    task automatic test_random_rays();
        vec3_t lo;
        vec3_t hi;
        int base;
        int span;
        for (int phase = 0; phase < 6; phase++)
        begin
            for (int a = 0; a < 3; a++)
            begin
                base = rand_span(20);
                span = $urandom_range(1 << 21);
                case (phase)
                    0:
                    begin
                        lo[a] = base;
                        hi[a] = base + span;
                    end
                    1:
                    begin
                        lo[a] = base + span;
                        hi[a] = base;
                    end
                    2:
                    begin
                        lo[a] = SAT_MIN;
                        hi[a] = SAT_MAX;
                    end
                    3:
                    begin
                        lo[a] = $urandom;
                        hi[a] = $urandom;
                    end
                    4:
                    begin
                        lo[a] = base;
                        hi[a] = (a == 0) ? base + span : base;
                    end
                    default:
                    begin
                        lo[a] = SAT_MAX;
                        hi[a] = SAT_MIN;
                    end
                endcase
            end
            settle();
            load_box(lo, hi);
            send_stream(PHASE_RAYS);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        origin_x = '0;
        origin_y = '0;
        origin_z = '0;
        inv_dir_x = '0;
        inv_dir_y = '0;
        inv_dir_z = '0;
        distance_limit = '0;
        limit_enable = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_axis_rays();
        test_zero_inverse();
        test_distance_limit();
        test_field_extremes();
        test_swapped_corners();
        test_flat_box();
        test_unused_index();
        test_random_rays();
        settle();
        repeat (PIPE_DEPTH + 10) @(posedge clk);
        if (error_count == 0)
            $display("[ray_box_slab_test_core] OK");
        else
            $display("[ray_box_slab_test_core] ERROR");
        $finish;
    end

endmodule
